/* rtl/core/tcps_pkg.sv */
// shared types and constants for the tick credit priority scheduler
// no dependencies
package tcps_pkg;

   localparam int NUM_TASKS_DEF = 4;
   localparam int MAX_TASKS     = 4;
   localparam int TASK_W        = 2;
   localparam int PRIO_W        = 8;
   localparam int TICK_W        = 32;
   localparam int CSR_ADDR_W    = 2;
   localparam int REQ_DATA_W    = 8;
   localparam int RSP_DATA_W    = 40;

   typedef logic [PRIO_W-1:0] prio_type;
   typedef prio_type [MAX_TASKS-1:0] prio_arr_type;

   localparam prio_arr_type PRIO_RESET = {8'd0, 8'd0, 8'd5, 8'd1};

   typedef struct packed {
      logic                  we;
      logic [CSR_ADDR_W-1:0] addr;
      prio_type              wdata;
   } csr_type;

   typedef struct packed {
      prio_type diff;
      logic     borrow;
      logic     gt;
   } cmp_res_type;

   typedef struct packed {
      logic [TICK_W-1:0] tick_total;
      logic              refilled;
      logic              switched;
      logic [TASK_W-1:0] running_task;
   } rsp_type;

endpackage

/* rtl/core/tcps_cmp.sv */
// shared 8-bit subtract and compare unit
// depends on tcps_pkg
module tcps_cmp
   import tcps_pkg::*;
(
   input  prio_type    op_a,
   input  prio_type    op_b,
   output cmp_res_type res
);

   logic [PRIO_W:0] sub;

   assign sub        = {1'b0, op_a} - {1'b0, op_b};
   assign res.diff   = sub[PRIO_W-1:0];
   assign res.borrow = sub[PRIO_W];
   assign res.gt     = !sub[PRIO_W] && (sub[PRIO_W-1:0] != '0);

endmodule

/* rtl/core/tcps_ctrl.sv */
// scheduling sequencer: credits, priorities, tick count, scan and refill passes
// depends on tcps_pkg and tcps_cmp
module tcps_ctrl
   import tcps_pkg::*;
#(
   parameter int NUM_TASKS = NUM_TASKS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    nested,
   input  csr_type csr,
   input  logic    out_free,
   output logic    idle,
   output logic    res_valid,
   output rsp_type res
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DEC    = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_REFILL = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   localparam logic [TASK_W-1:0] LAST = TASK_W'(NUM_TASKS - 1);

   logic [2:0]        state_ff, state_in;
   prio_arr_type      prio_ff, prio_in;
   prio_arr_type      credit_ff, credit_in;
   logic [TASK_W-1:0] cur_ff, cur_in;
   logic [TASK_W-1:0] old_ff, old_in;
   logic [TASK_W-1:0] idx_ff, idx_in;
   prio_type          best_ff, best_in;
   logic              nested_ff, nested_in;
   logic              refill_ff, refill_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;

   prio_type    op_a, op_b, dec_val, best_nx;
   cmp_res_type cmp;

   tcps_cmp u_cmp (
      .op_a (op_a),
      .op_b (op_b),
      .res  (cmp)
   );

   always_comb begin
      case (state_ff)
         S_DEC: begin
            op_a = credit_ff[cur_ff];
            op_b = prio_type'(1);
         end
         S_SCAN: begin
            op_a = credit_ff[idx_ff];
            op_b = best_ff;
         end
         S_REFILL: begin
            op_a = prio_ff[idx_ff];
            op_b = prio_ff[cur_ff];
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign dec_val = cmp.borrow ? '0 : cmp.diff;
   assign best_nx = cmp.gt ? op_a : best_ff;

   always_comb begin
      state_in  = state_ff;
      prio_in   = prio_ff;
      credit_in = credit_ff;
      cur_in    = cur_ff;
      old_in    = old_ff;
      idx_in    = idx_ff;
      best_in   = best_ff;
      nested_in = nested_ff;
      refill_in = refill_ff;
      ticks_in  = ticks_ff;
      res_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (csr.we) begin
               prio_in[csr.addr]   = csr.wdata;
               credit_in[csr.addr] = csr.wdata;
            end
            if (start) begin
               ticks_in  = ticks_ff + 1'b1;
               nested_in = nested;
               old_in    = cur_ff;
               refill_in = 1'b0;
               state_in  = S_DEC;
            end
         end
         S_DEC: begin
            credit_in[cur_ff] = dec_val;
            if (nested_ff || dec_val != '0) begin
               state_in = S_DONE;
            end else begin
               idx_in   = '0;
               best_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            best_in = best_nx;
            if (cmp.gt) begin
               cur_in = idx_ff;
            end
            if (idx_ff == LAST) begin
               if (best_nx == '0) begin
                  idx_in    = '0;
                  refill_in = 1'b1;
                  state_in  = S_REFILL;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_REFILL: begin
            credit_in[idx_ff] = prio_ff[idx_ff];
            if (cmp.gt) begin
               cur_in = idx_ff;
            end
            if (idx_ff == LAST) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DONE: begin
            res_valid = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         prio_ff   <= PRIO_RESET;
         credit_ff <= PRIO_RESET;
         cur_ff    <= '0;
         ticks_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         prio_ff   <= prio_in;
         credit_ff <= credit_in;
         cur_ff    <= cur_in;
         ticks_ff  <= ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      old_ff    <= old_in;
      idx_ff    <= idx_in;
      best_ff   <= best_in;
      nested_ff <= nested_in;
      refill_ff <= refill_in;
   end

   assign idle             = (state_ff == S_IDLE);
   assign res.running_task = cur_ff;
   assign res.switched     = (cur_ff != old_ff);
   assign res.refilled     = refill_ff;
   assign res.tick_total   = ticks_ff;

endmodule

/* rtl/core/tick_credit_priority_scheduler.sv */
// top level of the tick credit priority scheduler: stream ports, csr port, output register
// depends on tcps_pkg and tcps_ctrl
//
// channel   direction  handshake             payload
// req       in         req_tvalid/req_tready req_tdata[0] nested
// rsp       out        rsp_tvalid/rsp_tready rsp_tdata task, switched, refilled, tick_total
// csr       in         csr_we (no wait)      csr_addr, csr_wdata
//
// a tick runs the decrement step only when nested or credit remains, adds the credit scan
// when the credit runs out and the refill pass when no task has credit; no new tick is
// accepted before it is done; the shared 8-bit subtract/compare unit takes one task per cycle.
// reset restores priorities and credits to their defaults.
// the result sits in an output register; a full register holds the sequencer in its
// last step until the beat is taken.
module tick_credit_priority_scheduler
   import tcps_pkg::*;
#(
   parameter int NUM_TASKS = NUM_TASKS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [0] nested, rest zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [1:0] running_task, [2] switched,
                                              // [3] refilled, [35:4] tick_total
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  prio_type              csr_wdata
);

   logic    idle, start, out_free, res_valid;
   rsp_type res;
   csr_type csr;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign csr.we    = csr_we;
   assign csr.addr  = csr_addr;
   assign csr.wdata = csr_wdata;

   assign req_tready = idle;
   assign start      = req_tvalid && idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   tcps_ctrl #(
      .NUM_TASKS (NUM_TASKS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .nested    (req_tdata[0]),
      .csr       (csr),
      .out_free  (out_free),
      .idle      (idle),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(rsp_type)){1'b0}}, rsp_data_ff};

   // busy right after a tick is taken
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("scheduler ready right after accepting a tick");

   // chosen task is always one of the active tasks
   a_task_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[1:0]) < NUM_TASKS))
      else $error("running task outside the active task range");

   // a fresh result only appears while the sequencer is not accepting
   a_result_while_busy : assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !req_tready)
      else $error("result produced while idle");

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// testbench for tick_credit_priority_scheduler: timer ticks in, scheduling decisions out
// predicts each decision in a scoreboard class and checks every rsp beat in order
// depends on tcps_pkg and the scheduler rtl
module tb;
   import tcps_pkg::*;

   localparam int LIMIT_CYCLES     = 400000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_TICKS     = 1900;
   localparam int SETTLE_CYCLES    = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      PRIO_TASK0, PRIO_TASK1, PRIO_TASK2, PRIO_TASK3
   } csr_reg_type;

   typedef enum int {RSP_ALWAYS, RSP_RANDOM, RSP_PERIODIC, RSP_SPARSE} rsp_pace_type;

   class sched_board_type;
      prio_type          prio [MAX_TASKS];
      prio_type          credit [MAX_TASKS];
      logic [TASK_W-1:0] running;
      logic [TICK_W-1:0] ticks;
      rsp_type           due [$];
      int                errors, checked, nested_ticks, switches, refills;

      function new();
         for (int t = 0; t < MAX_TASKS; t++) begin
            prio[t]   = PRIO_RESET[t];
            credit[t] = PRIO_RESET[t];
         end
         running = '0;
         ticks   = '0;
      endfunction

      function void note_prio(int t, prio_type val);
         prio[t]   = val;
         credit[t] = val;
      endfunction

      function void note_tick(bit nested);
         logic [TASK_W-1:0] old_task, pick;
         prio_type          best;
         rsp_type           r;
         old_task = running;
         pick     = running;
         r.refilled = 1'b0;
         ticks++;
         if (credit[pick] != 0) credit[pick]--;
         if (!nested && credit[pick] == 0) begin
            best = '0;
            for (int t = 0; t < NUM_TASKS_DEF; t++) begin
               if (credit[t] > best) begin
                  best = credit[t];
                  pick = TASK_W'(t);
               end
            end
            if (best == 0) begin
               r.refilled = 1'b1;
               for (int t = 0; t < NUM_TASKS_DEF; t++) begin
                  credit[t] = prio[t];
                  if (prio[t] > prio[pick]) pick = TASK_W'(t);
               end
            end
         end
         running        = pick;
         r.running_task = pick;
         r.switched     = (pick != old_task);
         r.tick_total   = ticks;
         nested_ticks  += nested;
         switches      += r.switched;
         refills       += r.refilled;
         due.push_back(r);
      endfunction

      function void check(rsp_type got);
         rsp_type exp;
         checked++;
         if (due.size() == 0) begin
            $error("rsp beat with no tick outstanding: %h", got);
            errors++;
            return;
         end
         exp = due.pop_front();
         if (got.running_task !== exp.running_task) begin
            $error("running_task: expected %0d, got %0d", exp.running_task, got.running_task);
            errors++;
         end
         if (got.switched !== exp.switched) begin
            $error("switched: expected %0d, got %0d", exp.switched, got.switched);
            errors++;
         end
         if (got.refilled !== exp.refilled) begin
            $error("refilled: expected %0d, got %0d", exp.refilled, got.refilled);
            errors++;
         end
         if (got.tick_total !== exp.tick_total) begin
            $error("tick_total: expected %0d, got %0d", exp.tick_total, got.tick_total);
            errors++;
         end
      endfunction

      function int pending();
         return due.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // [0] nested
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [1:0] running_task, [2] switched,
                                            // [3] refilled, [35:4] tick_total
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   prio_type              csr_wdata  = '0;

   sched_board_type sb;
   rsp_pace_type    rsp_pace  = RSP_ALWAYS;
   bit              long_hold = 1'b0;
   int              cycles    = 0;
   int              prio_sets = 0;

   always #1 clock = ~clock;

   tick_credit_priority_scheduler #(.NUM_TASKS(NUM_TASKS_DEF)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL tick_credit_priority_scheduler");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]));
   end

   // receiver pacing, with an occasional long hold-off
   initial begin : rsp_side
      int cyc;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         case (rsp_pace)
            RSP_ALWAYS:   rsp_tready <= 1'b1;
            RSP_RANDOM:   rsp_tready <= ($urandom_range(0, 2) != 0);
            RSP_PERIODIC: rsp_tready <= ((cyc % 7) < 3);
            default:      rsp_tready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   task automatic send_tick(input bit nested);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, nested};
      do @(posedge clock); while (!req_tready);
      sb.note_tick(nested);
   endtask

   // back-to-back ticks, nested flags taken from the pattern lsb first
   task automatic send_pattern(input logic [31:0] pattern, input int count);
      for (int k = 0; k < count; k++) send_tick(pattern[k]);
      req_tvalid <= 1'b0;
   endtask

   task automatic run_ticks(input int count, input int nest_pct, input int gap_max);
      int burst, gap;
      burst = $urandom_range(1, 16);
      for (int k = 0; k < count; k++) begin
         send_tick($urandom_range(0, 99) < nest_pct);
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 16);
            gap   = $urandom_range(0, gap_max);
            if (gap != 0 && k != count - 1) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic settle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_prios(input prio_arr_type vals);
      for (int t = 0; t < MAX_TASKS; t++) begin
         csr_we    <= 1'b1;
         csr_addr  <= CSR_ADDR_W'(PRIO_TASK0 + t);
         csr_wdata <= vals[t];
         @(posedge clock);
         sb.note_prio(t, vals[t]);
      end
      csr_we <= 1'b0;
      prio_sets++;
   endtask

   function automatic prio_arr_type pick_prios();
      prio_arr_type v;
      int           kind;
      kind = $urandom_range(0, 9);
      for (int t = 0; t < MAX_TASKS; t++) begin
         case (kind)
            0:       v[t] = 8'd0;
            1:       v[t] = 8'd255;
            2:       v[t] = prio_type'($urandom_range(0, 255));
            3:       v[t] = (t == 0) ? prio_type'($urandom_range(1, 4)) : v[0];
            default: v[t] = prio_type'($urandom_range(0, 4));
         endcase
      end
      return v;
   endfunction

   initial begin : stimulus
      int sent, count, gap_max;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset priorities: nested ticks drain task 0, then switch to task 1 and refill
      send_pattern(32'b000000111, 9);
      settle();
      // all priorities zero: every plain tick refills
      write_prios({8'd0, 8'd0, 8'd0, 8'd0});
      send_pattern(32'b0100, 4);
      settle();
      // equal priorities: ties in credit and in refill
      write_prios({8'd2, 8'd2, 8'd2, 8'd2});
      send_pattern(32'b0, 8);
      settle();
      write_prios({8'd3, 8'd255, 8'd0, 8'd255});
      send_pattern(32'b0, 4);
      settle();

      sent = 0;
      while (sent < RANDOM_TICKS) begin
         write_prios(pick_prios());
         count   = $urandom_range(40, 160);
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
         rsp_pace = rsp_pace_type'($urandom_range(0, 3));
         if (sent == 0 || $urandom_range(0, 7) == 0) begin
            long_hold = 1'b1;
            gap_max   = 0;
         end
         run_ticks(count, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60), gap_max);
         sent += count;
         settle();
      end
      rsp_pace = RSP_ALWAYS;
      settle();

      $display("ticks checked: %0d (%0d nested), switches %0d, refills %0d",
               sb.checked, sb.nested_ticks, sb.switches, sb.refills);
      $display("priority settings applied: %0d", prio_sets);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS tick_credit_priority_scheduler");
      end else begin
         $display("FAIL tick_credit_priority_scheduler");
      end
      $finish;
   end

endmodule
